FILE: rtl/core/line_scan_stripe_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Line-scan stripe detector assertion macros
// Shorthand for the concurrent checks at the end of the top level. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINE_SCAN_STRIPE_DETECTOR_CORE_MACROS_SVH
`define LINE_SCAN_STRIPE_DETECTOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lssd_pkg.sv
// ----------------------------------------------------------------------------
// Line-scan stripe detector package
// Shared constants, types and the edge-judging functions of the detector.
// ----------------------------------------------------------------------------
package lssd_pkg;

    // Line geometry and limits
    localparam int LINE_PIXELS      = 128;
    localparam int MAX_EDGES        = 24;
    localparam int POS_W            = $clog2(LINE_PIXELS);
    localparam int EDGE_W           = $clog2(MAX_EDGES + 1);
    localparam int LOOKAHEAD_LIMIT  = LINE_PIXELS - 2;
    localparam int GAP_MIN          = 3;
    localparam int GAP_MAX          = 26;
    localparam int PAIR_W           = 5;
    localparam int PAIR_SAT         = 31;
    localparam int FINISH_MIN_PAIRS = 2;

    // Field widths
    localparam int SAMPLE_W  = 9;
    localparam int LEVEL_W   = 8;
    localparam int THR_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Division of the range magnitude by five: (x * 205) >> 10 for x < 256
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_MUL_W = 8;
    localparam int DIV5_SHIFT = 10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_HIGH = 1'b0,
        REG_LEVEL_LOW  = 1'b1
    } cfg_reg_t;

    // Edge thresholds, signed: range/4 and range/5 truncated toward zero
    typedef struct packed {
        logic signed [THR_W-1:0] q4;
        logic signed [THR_W-1:0] q5;
    } thr_t;

    // Per-line edge tracking state
    typedef struct packed {
        logic [EDGE_W-1:0] edges_taken;
        logic              last_neg;
        logic              last_zero;
        logic [POS_W-1:0]  last_pos;
        logic [PAIR_W-1:0] pair_count;
    } edge_state_t;

    // One result transaction
    typedef struct packed {
        logic              finish_seen;
        logic [PAIR_W-1:0] pair_total;
    } result_t;

    // Result offered by the tracker in the cycle it retires an item
    typedef struct packed {
        logic    valid;
        result_t result;
    } track_out_t;

    // Magnitude of a signed sample; the most negative code maps to 256.
    function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] m;
        m = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
        return m;
    endfunction

    // Magnitude strictly above a signed threshold.
    function automatic logic exceeds(input logic [SAMPLE_W-1:0] m,
                                     input logic signed [THR_W-1:0] q);
        logic above;
        above = q[THR_W-1] || (m > {{(SAMPLE_W-THR_W){1'b0}}, q});
        return above;
    endfunction

    // Record one edge and count a pair when it alternates with the last one.
    function automatic edge_state_t take_edge(input edge_state_t st,
                                              input logic signed [SAMPLE_W-1:0] v,
                                              input logic [POS_W-1:0] pos);
        edge_state_t      nst;
        logic             neg;
        logic             zero;
        logic [POS_W-1:0] gap;
        nst  = st;
        neg  = v[SAMPLE_W-1];
        zero = (v == '0);
        gap  = pos - st.last_pos;
        if ((st.edges_taken != '0) && !zero && !st.last_zero && (neg != st.last_neg)
            && (pos >= st.last_pos) && (gap >= POS_W'(GAP_MIN))
            && (gap <= POS_W'(GAP_MAX)) && (st.pair_count != PAIR_W'(PAIR_SAT)))
        begin
            nst.pair_count = st.pair_count + 1'b1;
        end
        nst.last_neg    = neg;
        nst.last_zero   = zero;
        nst.last_pos    = pos;
        nst.edges_taken = st.edges_taken + 1'b1;
        return nst;
    endfunction

    // Judge one position, optionally looking at the following sample.
    function automatic edge_state_t judge(input edge_state_t st,
                                          input thr_t thr,
                                          input logic signed [SAMPLE_W-1:0] s,
                                          input logic [POS_W-1:0] pos,
                                          input logic has_next,
                                          input logic signed [SAMPLE_W-1:0] nxt);
        edge_state_t         r;
        logic [SAMPLE_W-1:0] m;
        logic                same_sign;
        r = st;
        m = sample_mag(s);
        same_sign = (!s[SAMPLE_W-1] && (s != '0) && !nxt[SAMPLE_W-1] && (nxt != '0))
                    || (s[SAMPLE_W-1] && nxt[SAMPLE_W-1]);
        if (st.edges_taken < EDGE_W'(MAX_EDGES))
        begin
            if (exceeds(m, thr.q4))
            begin
                r = take_edge(st, s, pos);
            end
            else if (exceeds(m, thr.q5) && has_next
                     && (pos < POS_W'(LOOKAHEAD_LIMIT)) && same_sign)
            begin
                r = take_edge(st, nxt, pos + 1'b1);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lssd_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one signed difference sample and its line-end mark.
// ----------------------------------------------------------------------------
interface lssd_sample_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [lssd_pkg::SAMPLE_W-1:0]  diff_sample;
    logic                                  line_end;

    modport source (output valid, output diff_sample, output line_end, input ready);
    modport sink   (input valid, input diff_sample, input line_end, output ready);

endinterface

FILE: rtl/core/lssd_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the per-line stripe decision and pair count.
// ----------------------------------------------------------------------------
interface lssd_result_if;

    logic                          valid;
    logic                          ready;
    logic                          finish_seen;
    logic [lssd_pkg::PAIR_W-1:0]   pair_total;

    modport source (output valid, output finish_seen, output pair_total, input ready);
    modport sink   (input valid, input finish_seen, input pair_total, output ready);

endinterface

FILE: rtl/core/lssd_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the level range and keeps the quarter and fifth thresholds registered.
// ----------------------------------------------------------------------------
module lssd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lssd_pkg::LEVEL_W-1:0]     cfg_data,
    output lssd_pkg::thr_t                   thr
);

    logic [lssd_pkg::LEVEL_W-1:0]                      level_high_reg;
    logic [lssd_pkg::LEVEL_W-1:0]                      level_high_next;
    logic [lssd_pkg::LEVEL_W-1:0]                      level_low_reg;
    logic [lssd_pkg::LEVEL_W-1:0]                      level_low_next;
    logic signed [lssd_pkg::LEVEL_W:0]                 range;
    logic                                              range_neg;
    logic [lssd_pkg::LEVEL_W-1:0]                      range_mag;
    logic [lssd_pkg::LEVEL_W+lssd_pkg::DIV5_MUL_W-1:0] div5_prod;
    logic [lssd_pkg::THR_W-1:0]                        q4_mag;
    logic [lssd_pkg::THR_W-1:0]                        q5_mag;
    lssd_pkg::thr_t                                    thr_reg;
    lssd_pkg::thr_t                                    thr_next;

    // Register write decode
    always_comb
    begin
        level_high_next = level_high_reg;
        level_low_next  = level_low_reg;
        if (cfg_write)
        begin
            unique case (lssd_pkg::cfg_reg_t'(cfg_index))
                lssd_pkg::REG_LEVEL_HIGH: level_high_next = cfg_data;
                lssd_pkg::REG_LEVEL_LOW:  level_low_next  = cfg_data;
                default:                  ;
            endcase
        end
    end

    // Thresholds from the new levels, so they are valid the cycle after a write.
    always_comb
    begin
        range     = $signed({1'b0, level_high_next}) - $signed({1'b0, level_low_next});
        range_neg = range[lssd_pkg::LEVEL_W];
        range_mag = range_neg ? lssd_pkg::LEVEL_W'(-range) : lssd_pkg::LEVEL_W'(range);
        div5_prod = range_mag * lssd_pkg::DIV5_MUL_W'(lssd_pkg::DIV5_MUL);
        q4_mag    = lssd_pkg::THR_W'(range_mag >> 2);
        q5_mag    = lssd_pkg::THR_W'(div5_prod >> lssd_pkg::DIV5_SHIFT);
        thr_next.q4 = range_neg ? -$signed(q4_mag) : $signed(q4_mag);
        thr_next.q5 = range_neg ? -$signed(q5_mag) : $signed(q5_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_high_reg <= '1;
            level_low_reg  <= '0;
            thr_reg.q4     <= lssd_pkg::THR_W'(((1 << lssd_pkg::LEVEL_W) - 1) / 4);
            thr_reg.q5     <= lssd_pkg::THR_W'(((1 << lssd_pkg::LEVEL_W) - 1) / 5);
        end
        else
        begin
            level_high_reg <= level_high_next;
            level_low_reg  <= level_low_next;
            thr_reg        <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

FILE: rtl/core/lssd_track.sv
// ----------------------------------------------------------------------------
// Edge tracker
// Input register, per-line edge state and the two-position judging logic.
// ----------------------------------------------------------------------------
module lssd_track (
    input  logic                  clk,
    input  logic                  rst_n,
    lssd_sample_if.sink           samples,
    input  lssd_pkg::thr_t        thr,
    input  logic                  out_free,
    output lssd_pkg::track_out_t  track_out
);

    logic                                  s1_valid_reg;
    logic signed [lssd_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic                                  s1_end_reg;
    logic [lssd_pkg::POS_W-1:0]            pos_reg;
    logic signed [lssd_pkg::SAMPLE_W-1:0]  held_reg;
    lssd_pkg::edge_state_t                 est_reg;
    logic                                  fire;
    logic                                  line_last;
    lssd_pkg::edge_state_t                 st_prev;
    lssd_pkg::edge_state_t                 st_last;

    // The held transaction retires whenever the output register can take a result.
    assign fire          = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || fire;

    // Judge the previous position with look-ahead, then the last one on its own.
    always_comb
    begin
        line_last = s1_end_reg || (pos_reg == lssd_pkg::POS_W'(lssd_pkg::LINE_PIXELS - 1));
        st_prev   = est_reg;
        if (pos_reg >= lssd_pkg::POS_W'(2))
        begin
            st_prev = lssd_pkg::judge(est_reg, thr, held_reg, pos_reg - 1'b1,
                                      1'b1, s1_sample_reg);
        end
        st_last = st_prev;
        if (pos_reg != '0)
        begin
            st_last = lssd_pkg::judge(st_prev, thr, s1_sample_reg, pos_reg, 1'b0, '0);
        end
        track_out.valid              = fire && line_last;
        track_out.result.pair_total  = st_last.pair_count;
        track_out.result.finish_seen =
            (st_last.pair_count > lssd_pkg::PAIR_W'(lssd_pkg::FINISH_MIN_PAIRS));
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.diff_sample;
            s1_end_reg    <= samples.line_end;
        end
    end

    // Per-line state, cleared after each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            held_reg <= '0;
            est_reg  <= '0;
        end
        else if (fire)
        begin
            if (line_last)
            begin
                pos_reg  <= '0;
                held_reg <= '0;
                est_reg  <= '0;
            end
            else
            begin
                pos_reg  <= pos_reg + 1'b1;
                held_reg <= s1_sample_reg;
                est_reg  <= st_prev;
            end
        end
    end

endmodule

FILE: rtl/core/line_scan_stripe_detector_core.sv
// ----------------------------------------------------------------------------
// Line-scan stripe detector core
// Decides per sensor line whether it crosses a striped finish marker.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one signed pixel difference per transaction, line_end
//   marking the last sample of a line; a line also ends at its 128th sample.
//   results carries one transaction per line: finish_seen and pair_total.
//   The cfg_write/cfg_index/cfg_data port sets level_high and level_low and
//   is to be written only while no line is in flight.
// Flow:
//   One sample is taken every cycle while the result register can load. A
//   sample is held in the input register until it retires; the last sample
//   of a line retires into the result register, which drives results. Both
//   positions due at a line end are judged in the cycle that retires the
//   line's last sample.
// Reset:
//   Clears all line state and the result register; levels return to 255/0.
// Stalls:
//   While a result waits, one further sample is still taken into the input
//   register; ready then stays low until the result is taken.
// ----------------------------------------------------------------------------
`include "line_scan_stripe_detector_core_macros.svh"

module line_scan_stripe_detector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lssd_pkg::LEVEL_W-1:0]     cfg_data,
    lssd_sample_if.sink                      samples,
    lssd_result_if.source                    results
);

    lssd_pkg::thr_t        thr;
    lssd_pkg::track_out_t  track_out;
    logic                  out_free;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lssd_pkg::result_t     out_data_reg;
    logic                  finish_ok;
    logic                  pairs_ok;

    lssd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    lssd_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .thr       (thr),
        .out_free  (out_free),
        .track_out (track_out)
    );

    // Result register: loads whenever it is empty or being drained.
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = track_out.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && track_out.valid)
        begin
            out_data_reg <= track_out.result;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.finish_seen = out_data_reg.finish_seen;
    assign results.pair_total  = out_data_reg.pair_total;

    // Checks
    assign finish_ok = results.finish_seen
                       == (results.pair_total > lssd_pkg::PAIR_W'(lssd_pkg::FINISH_MIN_PAIRS));
    assign pairs_ok  = results.pair_total < lssd_pkg::PAIR_W'(lssd_pkg::MAX_EDGES);

    `LSSD_ASSERT_NOW(a_result_has_room, track_out.valid, out_free, "result produced with no room")
    `LSSD_ASSERT_NOW(a_finish_matches, results.valid, finish_ok, "finish_seen inconsistent")
    `LSSD_ASSERT_NOW(a_pairs_bounded, results.valid, pairs_ok, "more pairs than edges allow")
    `LSSD_ASSERT_NEXT(a_result_loaded, track_out.valid, results.valid, "line gave no result")

endmodule
